FILE: rtl/sta_lta_seismic_trigger_unit_macros.svh
// Assertion macros shared by the trigger RTL
`ifndef STA_LTA_SEISMIC_TRIGGER_UNIT_MACROS_SVH
`define STA_LTA_SEISMIC_TRIGGER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define STALTA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define STALTA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/stalta_pkg.sv
// Shared types and constants of the STA/LTA trigger
`timescale 1ns / 1ps
`default_nettype none
package stalta_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int RATIO_W = 16;
    localparam int STA_W   = 10;
    localparam int TRIG_W  = 4;
    localparam int REC_W   = 16;

    // Fraction bits of the Q8.8 ratio
    localparam int Q_SHIFT = 8;

    localparam logic [RATIO_W-1:0] RATIO_RST = 16'd768;
    localparam logic [STA_W-1:0]   STA_RST   = 10'd150;
    localparam logic [TRIG_W-1:0]  TRIG_RST  = 4'd4;
    localparam logic [REC_W-1:0]   REC_RST   = 16'd3000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RATIO = 3'd0,
        REG_STA   = 3'd1,
        REG_TRIG  = 3'd2,
        REG_REC   = 3'd3,
        REG_DET   = 3'd4
    } t_reg_idx;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_UPD   = 9'b000000010,
        ST_SWEEP = 9'b000000100,
        ST_DRAIN = 9'b000001000,
        ST_MLR   = 9'b000010000,
        ST_MLRS  = 9'b000100000,
        ST_MSD   = 9'b001000000,
        ST_CMP   = 9'b010000000,
        ST_DONE  = 9'b100000000
    } t_state;

endpackage
`default_nettype wire

FILE: rtl/stalta_in_if.sv
// Sample channel: valid/ready handshake carrying one acceleration sample
`timescale 1ns / 1ps
`default_nettype none
interface stalta_in_if #(
    parameter int SAMPLE_BITS = 16
) ();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] z_sample;

    modport source (output valid, output z_sample, input ready);
    modport sink   (input valid, input z_sample, output ready);
endinterface
`default_nettype wire

FILE: rtl/stalta_out_if.sv
// Result channel: valid/ready handshake carrying the trigger flags
`timescale 1ns / 1ps
`default_nettype none
interface stalta_out_if ();
    logic valid;
    logic ready;
    logic event_start;
    logic recording;
    logic window_full;
    logic over_ratio;

    modport source (output valid, output event_start, output recording,
                    output window_full, output over_ratio, input ready);
    modport sink   (input valid, input event_start, input recording,
                    input window_full, input over_ratio, output ready);
endinterface
`default_nettype wire

FILE: rtl/stalta_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
`default_nettype none
module stalta_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/sta_lta_seismic_trigger_unit.sv
// STA/LTA seismic event trigger: sample ring in RAM, deviation sweep, ratio test
`timescale 1ns / 1ps
`default_nettype none
//
//  Channel      Dir  Handshake         Payload
//  i_sample_ch  in   valid/ready       z_sample (SAMPLE_BITS, signed)
//  o_result_ch  out  valid/ready       event_start, recording, window_full, over_ratio
//  i_cfg_*      in   write enable only i_cfg_index (register number), i_cfg_data
//
//  One item in flight. Detection off: IDLE, DONE. Window filling or recording: IDLE, UPD, DONE.
//  Full test: IDLE, UPD, then a sweep over the sample RAM (one read per cycle), DRAIN
//  and three 16-step shift-add multiplies (MLR, MLRS, MSD) for the ratio test, then CMP, DONE.
//  Reset is synchronous; the sample RAM is not cleared (entries are read only once
//  written). A stalled result sits in the output register while the next item is
//  taken and processed; that item waits in its final state until the register frees.
//
module sta_lta_seismic_trigger_unit
    import stalta_pkg::*;
#(
    parameter int WINDOW_DEPTH = 512,
    parameter int SAMPLE_BITS  = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    stalta_in_if.sink                  i_sample_ch,
    stalta_out_if.source               o_result_ch,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Address, fill count and accumulator widths
    localparam int LDW = $clog2(WINDOW_DEPTH);
    localparam int FW  = $clog2(WINDOW_DEPTH + 1);
    localparam int TW  = SAMPLE_BITS + LDW + 1;      // window sum
    localparam int DW  = SAMPLE_BITS + LDW + 2;      // D*x - T
    localparam int ACW = DW + LDW;                   // deviation sums
    localparam int MW  = (RATIO_W > FW) ? RATIO_W : FW;
    localparam int MCW = $clog2(MW);
    localparam int PW  = ACW + RATIO_W + FW;         // products

    localparam logic signed [DW-1:0] DEPTH_S = DW'(WINDOW_DEPTH);

    t_state r_state;

    // configuration
    logic [RATIO_W-1:0] r_ratio;
    logic [STA_W-1:0]   r_sta;
    logic [TRIG_W-1:0]  r_trig;
    logic [REC_W-1:0]   r_rec_len;
    logic               r_det_en;

    // block state
    logic [LDW-1:0]        r_wp;
    logic [FW-1:0]         r_fill;
    logic                  r_full;
    logic signed [TW-1:0]  r_total;
    logic [TRIG_W-1:0]     r_exceed;
    logic                  r_rec;
    logic [REC_W-1:0]      r_elapsed;

    // per-item datapath
    logic [SAMPLE_BITS-1:0] r_x;
    logic [LDW-1:0]         r_raddr;
    logic [LDW-1:0]         r_k;
    logic                   r_p1_v;
    logic                   r_p2_v;
    logic                   r_f1;
    logic                   r_f2;
    logic [DW-1:0]          r_dabs;
    logic [ACW-1:0]         r_ldev;
    logic [ACW-1:0]         r_sdev;
    logic [PW-1:0]          r_mcand;
    logic [MW-1:0]          r_mplier;
    logic [PW-1:0]          r_macc;
    logic [MCW-1:0]         r_mstep;
    logic [PW-1:0]          r_lhs;
    logic                   r_start;
    logic                   r_over;
    logic                   r_out_valid;

    logic [SAMPLE_BITS-1:0] w_rdata;
    logic [LDW-1:0]         w_raddr;
    logic                   w_in_fire;
    logic                   w_out_load;
    logic signed [TW-1:0]   w_total_n;
    logic [FW-1:0]          w_fill_n;
    logic                   w_full_n;
    logic [LDW-1:0]         w_wp_n;
    logic [FW-1:0]          w_s;
    logic                   w_in_sta;
    logic signed [DW-1:0]   w_rx;
    logic signed [DW-1:0]   w_dx;
    logic signed [DW-1:0]   w_d;
    logic [DW-1:0]          w_dabs;
    logic [REC_W-1:0]       w_elapsed_n;
    logic [PW-1:0]          w_madd;
    logic                   w_mlast;
    logic [TRIG_W-1:0]      w_exc_inc;
    logic                   w_pass;
    logic                   w_fire;

    // Ring of samples; read port serves the outgoing sample and the sweep
    stalta_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (r_state == ST_UPD),
        .i_waddr (r_wp),
        .i_wdata (r_x),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign i_sample_ch.ready = (r_state == ST_IDLE);
    assign w_in_fire  = i_sample_ch.valid && i_sample_ch.ready;
    assign w_out_load = (r_state == ST_DONE) && (!r_out_valid || o_result_ch.ready);
    assign w_raddr    = (r_state == ST_IDLE) ? r_wp : r_raddr;

    // Window bookkeeping; RAM output holds the sample being overwritten
    assign w_total_n = r_total - (r_full ? TW'($signed(w_rdata)) : TW'(0))
                     + TW'($signed(r_x));
    assign w_fill_n  = r_full ? r_fill : r_fill + 1'b1;
    assign w_full_n  = (w_fill_n == FW'(WINDOW_DEPTH));
    assign w_wp_n    = (r_wp == LDW'(WINDOW_DEPTH - 1)) ? '0 : r_wp + 1'b1;

    // Short-term length clamped to the window
    assign w_s      = (32'(r_sta) > 32'(WINDOW_DEPTH)) ? FW'(WINDOW_DEPTH) : FW'(r_sta);
    assign w_in_sta = FW'(r_k) < w_s;

    // |D*x - T| for the sample on the RAM output
    assign w_rx   = DW'($signed(w_rdata));
    assign w_dx   = w_rx * DEPTH_S;
    assign w_d    = w_dx - DW'(r_total);
    assign w_dabs = w_d[DW-1] ? DW'(-w_d) : DW'(w_d);

    assign w_elapsed_n = (r_elapsed != '1) ? r_elapsed + 1'b1 : r_elapsed;

    // shift-add multiplier step
    assign w_madd  = r_macc + (r_mplier[0] ? r_mcand : '0);
    assign w_mlast = (r_mstep == MCW'(MW - 1));

    // Ldev*R*S < Sdev*256*D
    assign w_pass    = r_lhs < (r_macc << Q_SHIFT);
    assign w_exc_inc = r_exceed + 1'b1;
    assign w_fire    = w_pass && (w_exc_inc >= r_trig);

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ratio     <= RATIO_RST;
            r_sta       <= STA_RST;
            r_trig      <= TRIG_RST;
            r_rec_len   <= REC_RST;
            r_det_en    <= 1'b1;
            r_wp        <= '0;
            r_fill      <= '0;
            r_full      <= 1'b0;
            r_total     <= '0;
            r_exceed    <= '0;
            r_rec       <= 1'b0;
            r_elapsed   <= '0;
            r_p1_v      <= 1'b0;
            r_p2_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_p1_v <= (r_state == ST_SWEEP);
            r_p2_v <= r_p1_v;

            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_RATIO: r_ratio   <= i_cfg_data[RATIO_W-1:0];
                    REG_STA:   r_sta     <= i_cfg_data[STA_W-1:0];
                    REG_TRIG:  r_trig    <= i_cfg_data[TRIG_W-1:0];
                    REG_REC:   r_rec_len <= i_cfg_data[REC_W-1:0];
                    REG_DET:   r_det_en  <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_result_ch.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_in_fire) begin
                        r_state <= r_det_en ? ST_UPD : ST_DONE;
                    end
                end
                ST_UPD: begin
                    r_total <= w_total_n;
                    r_fill  <= w_fill_n;
                    r_full  <= w_full_n;
                    r_wp    <= w_wp_n;
                    if (r_rec) begin
                        // recording: count samples, no test
                        r_elapsed <= w_elapsed_n;
                        if (w_elapsed_n >= r_rec_len) begin
                            r_rec <= 1'b0;
                        end
                        r_state <= ST_DONE;
                    end else if (w_full_n) begin
                        r_state <= ST_SWEEP;
                    end else begin
                        r_state <= ST_DONE;
                    end
                end
                ST_SWEEP: begin
                    if (r_k == LDW'(WINDOW_DEPTH - 1)) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!r_p1_v && !r_p2_v) begin
                        // a zero deviation sum means no test, count kept
                        r_state <= (r_ldev == '0 || r_sdev == '0) ? ST_DONE : ST_MLR;
                    end
                end
                ST_MLR: begin
                    if (w_mlast) begin
                        r_state <= ST_MLRS;
                    end
                end
                ST_MLRS: begin
                    if (w_mlast) begin
                        r_state <= ST_MSD;
                    end
                end
                ST_MSD: begin
                    if (w_mlast) begin
                        r_state <= ST_CMP;
                    end
                end
                ST_CMP: begin
                    if (w_pass) begin
                        if (w_fire) begin
                            r_exceed  <= '0;
                            r_rec     <= 1'b1;
                            r_elapsed <= '0;
                        end else begin
                            r_exceed <= w_exc_inc;
                        end
                    end else begin
                        r_exceed <= '0;
                    end
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (w_out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_in_fire) begin
                    r_x     <= i_sample_ch.z_sample;
                    r_start <= 1'b0;
                    r_over  <= 1'b0;
                end
            end
            ST_UPD: begin
                // newest sample sits at the old write pointer
                r_raddr <= r_wp;
                r_k     <= '0;
                r_ldev  <= '0;
                r_sdev  <= '0;
            end
            ST_SWEEP: begin
                r_f1    <= w_in_sta;
                r_raddr <= (r_raddr == '0) ? LDW'(WINDOW_DEPTH - 1) : r_raddr - 1'b1;
                r_k     <= r_k + 1'b1;
            end
            ST_DRAIN: begin
                r_mcand  <= PW'(r_ldev);
                r_mplier <= MW'(r_ratio);
                r_macc   <= '0;
                r_mstep  <= '0;
            end
            ST_MLR: begin
                if (w_mlast) begin
                    r_mcand  <= w_madd;
                    r_mplier <= MW'(w_s);
                    r_macc   <= '0;
                    r_mstep  <= '0;
                end else begin
                    r_macc   <= w_madd;
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                    r_mstep  <= r_mstep + 1'b1;
                end
            end
            ST_MLRS: begin
                if (w_mlast) begin
                    r_lhs    <= w_madd;
                    r_mcand  <= PW'(r_sdev);
                    r_mplier <= MW'(WINDOW_DEPTH);
                    r_macc   <= '0;
                    r_mstep  <= '0;
                end else begin
                    r_macc   <= w_madd;
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                    r_mstep  <= r_mstep + 1'b1;
                end
            end
            ST_MSD: begin
                r_macc   <= w_madd;
                r_mcand  <= r_mcand << 1;
                r_mplier <= r_mplier >> 1;
                r_mstep  <= r_mstep + 1'b1;
            end
            ST_CMP: begin
                r_over  <= w_pass;
                r_start <= w_fire;
            end
            ST_DONE: begin
                if (w_out_load) begin
                    o_result_ch.event_start <= r_start;
                    o_result_ch.recording   <= r_rec;
                    o_result_ch.window_full <= r_full;
                    o_result_ch.over_ratio  <= r_over;
                end
            end
            default: ;
        endcase

        // sweep pipeline: RAM data -> |D*x - T| -> sums
        if (r_p1_v) begin
            r_dabs <= w_dabs;
            r_f2   <= r_f1;
        end
        if (r_p2_v) begin
            r_ldev <= r_ldev + ACW'(r_dabs);
            if (r_f2) begin
                r_sdev <= r_sdev + ACW'(r_dabs);
            end
        end
    end

    assign o_result_ch.valid = r_out_valid;

`include "sta_lta_seismic_trigger_unit_macros.svh"

    `STALTA_ASSERT_NOW(a_start_records, o_result_ch.valid && o_result_ch.event_start, o_result_ch.recording, "event start without recording")
    `STALTA_ASSERT_NOW(a_over_needs_full, o_result_ch.valid && o_result_ch.over_ratio, o_result_ch.window_full, "over ratio before window full")
    `STALTA_ASSERT_NEXT(a_full_sticks, r_full, r_full, "window full flag dropped")
    `STALTA_ASSERT_NOW(a_sweep_full, r_state == ST_SWEEP, r_full && !r_rec, "sweep without full window")

endmodule
`default_nettype wire
